FILE: rtl/core/sample_voice_resampler_unit_assert.svh
// Assertion macros for the sample voice resampler checker.
// Needs clk and rst_n in the scope where a macro is used.
`ifndef SAMPLE_VOICE_RESAMPLER_UNIT_ASSERT_SVH
`define SAMPLE_VOICE_RESAMPLER_UNIT_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define SVR_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("svr_checker: same-cycle check failed");

// Next-cycle implication, disabled during reset.
`define SVR_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("svr_checker: next-cycle check failed");

`endif

FILE: rtl/core/svr_pkg.sv
// Shared types and constants of the sample voice resampler.
// No dependencies; used by svr_front, svr_back and the top level.
package svr_pkg;

  // Item opcodes
  typedef enum logic [1:0] {
    OP_WRITE  = 2'd0,
    OP_START  = 2'd1,
    OP_STOP   = 2'd2,
    OP_RENDER = 2'd3
  } opcode_t;

  // Configuration register indexes
  localparam logic [2:0] REG_LOOP_ENABLE  = 3'd0;
  localparam logic [2:0] REG_STEREO       = 3'd1;
  localparam logic [2:0] REG_START_FRAME  = 3'd2;
  localparam logic [2:0] REG_END_FRAME    = 3'd3;
  localparam logic [2:0] REG_TOTAL_FRAMES = 3'd4;
  localparam logic [2:0] REG_STEP_INC     = 3'd5;
  localparam logic [2:0] REG_VOLUME       = 3'd6;
  localparam logic [2:0] REG_PAN          = 3'd7;

  localparam logic [23:0] STEP_RESET   = 24'd65536;
  localparam logic [14:0] VOLUME_RESET = 15'd16384;

  localparam int CMDQ_DEPTH = 2;

  typedef struct packed {
    logic               loop_enable;
    logic               stereo;
    logic [15:0]        start_frame;
    logic [16:0]        end_frame;
    logic [16:0]        total_frames;
    logic [23:0]        step_inc;
    logic [14:0]        volume;
    logic signed [15:0] pan;
  } cfg_t;

  typedef struct packed {
    opcode_t            op;
    logic [15:0]        address;
    logic signed [15:0] sample;
    logic               hold;
  } cmd_t;

  // Head of the command queue as seen by the back end
  typedef struct packed {
    logic valid;
    cmd_t cmd;
  } q_head_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RD0,
    ST_RD1,
    ST_DIFF,
    ST_INTERP,
    ST_VOL,
    ST_GAIN,
    ST_FINISH
  } back_state_t;

  // Clamp to 19-bit signed output range
  function automatic logic signed [18:0] sat_out(input logic signed [23:0] v);
    logic signed [18:0] r;
    if (v > 24'sd262143) begin
      r = 19'sd262143;
    end else if (v < -24'sd262144) begin
      r = -19'sd262144;
    end else begin
      r = $signed(v[18:0]);
    end
    return r;
  endfunction

endpackage

FILE: rtl/core/svr_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module svr_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    rd_data_r <= mem_r[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

FILE: rtl/core/svr_front.sv
// Front end: accepts items, drops out-of-range writes, queues commands.
// Depends on svr_pkg.
module svr_front #(
  parameter int SAMPLE_WORDS = 65536
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [1:0]            in_opcode,
  input  logic [15:0]           in_address,
  input  logic signed [15:0]    in_sample_value,
  input  logic                  in_hold,
  input  logic                  pop,
  output svr_pkg::q_head_t      head
);

  svr_pkg::cmd_t q_r [svr_pkg::CMDQ_DEPTH];
  logic          wr_ptr_r, wr_ptr_nxt;
  logic          rd_ptr_r, rd_ptr_nxt;
  logic [1:0]    count_r, count_nxt;
  logic          accept, keep, push;
  svr_pkg::cmd_t cmd_in;

  assign in_stall = (count_r == 2'(svr_pkg::CMDQ_DEPTH));
  assign accept   = in_valid && !in_stall;

  always_comb begin
    cmd_in.op      = svr_pkg::opcode_t'(in_opcode);
    cmd_in.address = in_address;
    cmd_in.sample  = in_sample_value;
    cmd_in.hold    = in_hold;
  end

  // writes past the end of memory have no effect at all
  assign keep = !((cmd_in.op == svr_pkg::OP_WRITE) && !(32'(in_address) < SAMPLE_WORDS));
  assign push = accept && keep;

  always_comb begin
    wr_ptr_nxt = push ? !wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? !rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r + 2'(push) - 2'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_ptr_r] <= cmd_in;
    end
  end

  assign head.valid = (count_r != 2'd0);
  assign head.cmd   = q_r[rd_ptr_r];

endmodule

FILE: rtl/core/svr_back.sv
// Back end: voice state, sample memory, interpolation and gain sequencer.
// Depends on svr_pkg and svr_ram.
module svr_back #(
  parameter int SAMPLE_WORDS = 65536,
  parameter int FRAC_BITS    = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  svr_pkg::cfg_t         cfg,
  input  svr_pkg::q_head_t      head,
  output logic                  pop,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic signed [18:0]    out_left_out,
  output logic signed [18:0]    out_right_out,
  output logic                  out_playing_flag
);

  localparam int POS_W = FRAC_BITS + 18;
  localparam int AW    = $clog2(SAMPLE_WORDS);
  localparam int T_W   = FRAC_BITS + 18;

  svr_pkg::back_state_t state_r, state_nxt;

  logic [POS_W-1:0]   pos_r, pos_nxt;
  logic               playing_r, playing_nxt;
  logic [16:0]        eff_end_r, eff_end_nxt;
  logic               chan_r, chan_nxt;
  logic signed [17:0] gl_r, gl_nxt, gr_r, gr_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic signed [18:0] out_left_r, out_left_nxt, out_right_r, out_right_nxt;
  logic               out_flag_r, out_flag_nxt;

  // datapath registers
  logic signed [15:0] s0_r;
  logic signed [16:0] diff_r;
  logic signed [15:0] samp_r;
  logic signed [31:0] sv_r;
  logic signed [49:0] pl_r, pr_r;
  logic signed [18:0] res_l_r, res_r_r;
  logic               zero_r;

  logic               out_free, at_end;
  logic [17:0]        pos_int;
  logic [18:0]        frame;
  logic [19:0]        word_addr;
  logic               rd_zero;
  logic [15:0]        ram_q;
  logic signed [15:0] rd_sample;
  logic               ram_we;
  logic signed [T_W-1:0] interp_t;
  logic signed [49:0] pl_rnd, pr_rnd;
  logic signed [31:0] sv_rnd;
  logic signed [18:0] mono_l, mono_r, ster_v;

  assign pos_int = pos_r[POS_W-1:FRAC_BITS];
  assign at_end  = pos_int >= {1'b0, eff_end_r};

  // read address: frame idx (s0) or idx+1 (s1), interleaved when stereo
  assign frame     = {1'b0, pos_int} + 19'(state_r == svr_pkg::ST_RD1);
  assign word_addr = cfg.stereo ? {frame, chan_r} : {1'b0, frame};
  assign rd_zero   = (frame >= {2'b00, cfg.total_frames}) || (32'(word_addr) >= SAMPLE_WORDS);

  svr_ram #(
    .WIDTH(16),
    .DEPTH(SAMPLE_WORDS)
  ) u_mem (
    .clk    (clk),
    .wr_en  (ram_we),
    .wr_addr(AW'(head.cmd.address)),
    .wr_data(head.cmd.sample),
    .rd_addr(AW'(word_addr)),
    .rd_data(ram_q)
  );

  assign rd_sample = zero_r ? 16'sd0 : $signed(ram_q);

  // t = s0*2^F + frac*(s1-s0); floor by dropping F bits
  assign interp_t = $signed({{2{s0_r[15]}}, s0_r, {FRAC_BITS{1'b0}}})
                  + $signed({1'b0, pos_r[FRAC_BITS-1:0]}) * diff_r;

  assign pl_rnd = pl_r + (50'sd1 <<< 28);
  assign pr_rnd = pr_r + (50'sd1 <<< 28);
  assign sv_rnd = sv_r + 32'sd8192;
  assign mono_l = svr_pkg::sat_out(24'($signed(pl_rnd[49:29])));
  assign mono_r = svr_pkg::sat_out(24'($signed(pr_rnd[49:29])));
  assign ster_v = svr_pkg::sat_out(24'($signed(sv_rnd[31:14])));

  assign out_free = !out_valid_r || !out_stall;

  always_comb begin
    state_nxt     = state_r;
    pos_nxt       = pos_r;
    playing_nxt   = playing_r;
    eff_end_nxt   = eff_end_r;
    chan_nxt      = chan_r;
    gl_nxt        = gl_r;
    gr_nxt        = gr_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_left_nxt  = out_left_r;
    out_right_nxt = out_right_r;
    out_flag_nxt  = out_flag_r;
    pop           = 1'b0;
    ram_we        = 1'b0;
    unique case (state_r)
      svr_pkg::ST_IDLE: begin
        if (head.valid) begin
          unique case (head.cmd.op)
            svr_pkg::OP_WRITE: begin
              pop    = 1'b1;
              ram_we = 1'b1;
            end
            svr_pkg::OP_START: begin
              pop         = 1'b1;
              eff_end_nxt = ((cfg.end_frame == 17'd0) || (cfg.end_frame > cfg.total_frames))
                          ? cfg.total_frames : cfg.end_frame;
              pos_nxt     = {2'b00, cfg.start_frame, {FRAC_BITS{1'b0}}};
              playing_nxt = 1'b1;
            end
            svr_pkg::OP_STOP: begin
              pop         = 1'b1;
              playing_nxt = 1'b0;
            end
            svr_pkg::OP_RENDER: begin
              if (out_free) begin
                pop = 1'b1;
                if (!playing_r || head.cmd.hold) begin
                  out_valid_nxt = 1'b1;
                  out_left_nxt  = '0;
                  out_right_nxt = '0;
                  out_flag_nxt  = playing_r;
                end else if (at_end && !cfg.loop_enable) begin
                  playing_nxt   = 1'b0;
                  out_valid_nxt = 1'b1;
                  out_left_nxt  = '0;
                  out_right_nxt = '0;
                  out_flag_nxt  = 1'b0;
                end else begin
                  if (at_end) begin
                    pos_nxt = '0;
                  end
                  chan_nxt  = 1'b0;
                  gl_nxt    = 18'sd32768 - 18'($signed(cfg.pan));
                  gr_nxt    = 18'sd32768 + 18'($signed(cfg.pan));
                  state_nxt = svr_pkg::ST_RD0;
                end
              end
            end
          endcase
        end
      end
      svr_pkg::ST_RD0:    state_nxt = svr_pkg::ST_RD1;
      svr_pkg::ST_RD1:    state_nxt = svr_pkg::ST_DIFF;
      svr_pkg::ST_DIFF:   state_nxt = svr_pkg::ST_INTERP;
      svr_pkg::ST_INTERP: state_nxt = svr_pkg::ST_VOL;
      svr_pkg::ST_VOL:    state_nxt = svr_pkg::ST_GAIN;
      svr_pkg::ST_GAIN: begin
        if (cfg.stereo && !chan_r) begin
          chan_nxt  = 1'b1;
          state_nxt = svr_pkg::ST_RD0;
        end else begin
          state_nxt = svr_pkg::ST_FINISH;
        end
      end
      svr_pkg::ST_FINISH: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_left_nxt  = cfg.stereo ? res_l_r : mono_l;
          out_right_nxt = cfg.stereo ? res_r_r : mono_r;
          out_flag_nxt  = playing_r;
          pos_nxt       = pos_r + POS_W'(cfg.step_inc);
          state_nxt     = svr_pkg::ST_IDLE;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= svr_pkg::ST_IDLE;
      pos_r       <= '0;
      playing_r   <= 1'b0;
      eff_end_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      pos_r       <= pos_nxt;
      playing_r   <= playing_nxt;
      eff_end_r   <= eff_end_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    chan_r      <= chan_nxt;
    gl_r        <= gl_nxt;
    gr_r        <= gr_nxt;
    out_left_r  <= out_left_nxt;
    out_right_r <= out_right_nxt;
    out_flag_r  <= out_flag_nxt;
    zero_r      <= rd_zero;
    case (state_r)
      svr_pkg::ST_RD1:    s0_r   <= rd_sample;
      svr_pkg::ST_DIFF:   diff_r <= $signed({rd_sample[15], rd_sample})
                                  - $signed({s0_r[15], s0_r});
      svr_pkg::ST_INTERP: samp_r <= $signed(interp_t[FRAC_BITS+15:FRAC_BITS]);
      svr_pkg::ST_VOL:    sv_r   <= samp_r * $signed({1'b0, cfg.volume});
      svr_pkg::ST_GAIN: begin
        if (cfg.stereo) begin
          if (chan_r) begin
            res_r_r <= ster_v;
          end else begin
            res_l_r <= ster_v;
          end
        end else begin
          pl_r <= sv_r * gl_r;
          pr_r <= sv_r * gr_r;
        end
      end
      default: ;
    endcase
  end

  assign out_valid        = out_valid_r;
  assign out_left_out     = out_left_r;
  assign out_right_out    = out_right_r;
  assign out_playing_flag = out_flag_r;

endmodule

FILE: rtl/core/sample_voice_resampler_unit.sv
// Top level of the sample voice resampler: configuration registers plus
// front end (svr_front) and back end (svr_back). Depends on svr_pkg.
//
// One playback voice over an internal sample RAM of 16-bit PCM words, mono or
// interleaved stereo. Items carry an opcode: write a sample word, start, stop,
// or render one output frame; only render returns a result item. The front
// end takes an item every cycle while its two-entry command queue has room,
// and drops writes past the end of memory. The back end runs one command at
// a time: write, start, stop and a silent render (voice not playing, hold
// set, or end reached without loop) complete from the idle state; a playing
// render runs the states RD0, RD1, DIFF, INTERP, VOL and GAIN once per
// channel and then FINISH, paced by the single read port of the sample RAM
// (two reads per channel, registered read data). Results sit in an output
// register; while one waits, writes, starts and stops go on, but the next
// render holds at the queue head until the register frees.
// Interpolation is linear between adjacent frames with a FRAC_BITS position
// fraction; frames at or past total_frames read as zero. Mono is panned with
// constant-sum gains and volume, stereo uses volume only; outputs are Q3.15
// saturated to 19 bits. The configuration port is always ready and is meant
// to be written only while the block is idle.
module sample_voice_resampler_unit #(
  parameter int SAMPLE_WORDS = 65536,
  parameter int FRAC_BITS    = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  // item input
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         in_opcode,
  input  logic [15:0]        in_address,
  input  logic signed [15:0] in_sample_value,
  input  logic               in_hold,
  // result output
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [18:0] out_left_out,
  output logic signed [18:0] out_right_out,
  output logic               out_playing_flag,
  // configuration writes
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [23:0]        cfg_data
);

  svr_pkg::cfg_t    cfg_r, cfg_nxt;
  svr_pkg::q_head_t head;
  logic             pop;

  assign cfg_ready = 1'b1;

  // register file; all indexes map to a register
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        svr_pkg::REG_LOOP_ENABLE:  cfg_nxt.loop_enable  = cfg_data[0];
        svr_pkg::REG_STEREO:       cfg_nxt.stereo       = cfg_data[0];
        svr_pkg::REG_START_FRAME:  cfg_nxt.start_frame  = cfg_data[15:0];
        svr_pkg::REG_END_FRAME:    cfg_nxt.end_frame    = cfg_data[16:0];
        svr_pkg::REG_TOTAL_FRAMES: cfg_nxt.total_frames = cfg_data[16:0];
        svr_pkg::REG_STEP_INC:     cfg_nxt.step_inc     = cfg_data[23:0];
        svr_pkg::REG_VOLUME:       cfg_nxt.volume       = cfg_data[14:0];
        svr_pkg::REG_PAN:          cfg_nxt.pan          = $signed(cfg_data[15:0]);
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.loop_enable  <= 1'b0;
      cfg_r.stereo       <= 1'b0;
      cfg_r.start_frame  <= '0;
      cfg_r.end_frame    <= '0;
      cfg_r.total_frames <= '0;
      cfg_r.step_inc     <= svr_pkg::STEP_RESET;
      cfg_r.volume       <= svr_pkg::VOLUME_RESET;
      cfg_r.pan          <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // front: accept and classify, queue commands
  svr_front #(
    .SAMPLE_WORDS(SAMPLE_WORDS)
  ) u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_opcode      (in_opcode),
    .in_address     (in_address),
    .in_sample_value(in_sample_value),
    .in_hold        (in_hold),
    .pop            (pop),
    .head           (head)
  );

  // back: voice state, memory and arithmetic
  svr_back #(
    .SAMPLE_WORDS(SAMPLE_WORDS),
    .FRAC_BITS   (FRAC_BITS)
  ) u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg             (cfg_r),
    .head            (head),
    .pop             (pop),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_left_out    (out_left_out),
    .out_right_out   (out_right_out),
    .out_playing_flag(out_playing_flag)
  );

endmodule

FILE: rtl/core/svr_checker.sv
// Port-level checker for sample_voice_resampler_unit, attached by bind.
// Depends on sample_voice_resampler_unit_assert.svh.
`include "sample_voice_resampler_unit_assert.svh"

module svr_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_stall,
  input logic [1:0]         in_opcode,
  input logic [15:0]        in_address,
  input logic signed [15:0] in_sample_value,
  input logic               in_hold,
  input logic               out_valid,
  input logic               out_stall,
  input logic signed [18:0] out_left_out,
  input logic signed [18:0] out_right_out,
  input logic               out_playing_flag,
  input logic               cfg_valid,
  input logic               cfg_ready,
  input logic [2:0]         cfg_index,
  input logic [23:0]        cfg_data
);

  // result fields as one word: left, right, flag in the low bit
  logic [38:0] out_item;

  assign out_item = {out_left_out, out_right_out, out_playing_flag};

  // a stalled result item holds
  `SVR_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_item))

  // a voice that is not playing after the frame only ever gives silence
  `SVR_ASSERT_SAME(a_silent_stopped, out_valid && !out_playing_flag, out_item[38:1] == '0)

  // no stale result survives reset
  `SVR_ASSERT_SAME(a_reset_clean, $rose(rst_n), !out_valid)

endmodule

bind sample_voice_resampler_unit svr_checker u_svr_checker (.*);
